[rtl/core/deq_pkg.sv]
// deq_pkg: shared constants and types of the double-ended queue
// field widths, command and status codes, controller command bundle
// no dependencies
`default_nettype none

package deq_pkg;

  localparam int unsigned DEQ_DEPTH     = 1024;
  localparam int unsigned DEQ_WORD_BITS = 32;

  localparam int unsigned CMD_BITS    = 3;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned COUNT_BITS  = 11;
  localparam int unsigned STATUS_BITS = 2;

  localparam logic [CMD_BITS-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_PEEK       = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic latch;
    logic exec;
    logic read;
    logic load;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

[rtl/core/deq_cmd_if.sv]
// deq_cmd_if: command channel of the double-ended queue
// valid/ready handshake carrying command and value; depends on deq_pkg
`default_nettype none

interface deq_cmd_if import deq_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic        [CMD_BITS-1:0]    command;
  logic signed [VALUE_BITS-1:0]  value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

`default_nettype wire

[rtl/core/deq_rsp_if.sv]
// deq_rsp_if: result channel of the double-ended queue
// valid/ready handshake carrying front/back words, count, flags; depends on deq_pkg
`default_nettype none

interface deq_rsp_if import deq_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_BITS-1:0]  front_word;
  logic signed [VALUE_BITS-1:0]  back_word;
  logic        [COUNT_BITS-1:0]  element_count;
  logic                          is_empty;
  logic        [STATUS_BITS-1:0] status;

  modport source (output valid, front_word, back_word, element_count, is_empty, status,
                  input ready);
  modport sink   (input valid, front_word, back_word, element_count, is_empty, status,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/deq_ctrl.sv]
// deq_ctrl: sequencing state machine of the double-ended queue
// drives datapath commands and both handshakes; depends on deq_pkg
`default_nettype none

module deq_ctrl import deq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/deq_dp.sv]
// deq_dp: datapath of the double-ended queue
// ring store, head and count registers, status and result registers; depends on deq_pkg
`default_nettype none

module deq_dp import deq_pkg::*; #(
  parameter int unsigned DEPTH     = DEQ_DEPTH,
  parameter int unsigned WORD_BITS = DEQ_WORD_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ctrl_cmd_t                     cmd_i,
  input  wire logic        [CMD_BITS-1:0]    command_i,
  input  wire logic signed [VALUE_BITS-1:0]  value_i,
  output logic signed      [VALUE_BITS-1:0]  front_word_o,
  output logic signed      [VALUE_BITS-1:0]  back_word_o,
  output logic             [COUNT_BITS-1:0]  element_count_o,
  output logic                               is_empty_o,
  output logic             [STATUS_BITS-1:0] status_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;

  localparam logic [PtrW-1:0] LastIdx  = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(DEPTH);
  localparam logic [SumW-1:0] DepthSum = SumW'(DEPTH);

  logic [WORD_BITS-1:0] ring_store_q [DEPTH];

  logic [CMD_BITS-1:0]    command_q;
  logic [WORD_BITS-1:0]   word_q;
  logic [PtrW-1:0]        head_q, head_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [STATUS_BITS-1:0] status_q, status_d;
  logic [WORD_BITS-1:0]   front_rd_q, back_rd_q;

  logic [VALUE_BITS-1:0]  front_word_q, back_word_q;
  logic [COUNT_BITS-1:0]  element_count_q;
  logic                   is_empty_q;
  logic [STATUS_BITS-1:0] rsp_status_q;

  logic            is_push, is_full, is_empty, wr_en;
  logic [PtrW-1:0] head_prev, head_next, tail_idx, back_idx, wr_idx;
  logic [SumW-1:0] tail_sum, back_sum;

  assign is_push  = (command_q == CMD_PUSH_FRONT) || (command_q == CMD_PUSH_BACK);
  assign is_full  = (count_q == FullCnt);
  assign is_empty = (count_q == '0);

  assign head_prev = (head_q == '0) ? LastIdx : head_q - 1'b1;
  assign head_next = (head_q == LastIdx) ? '0 : head_q + 1'b1;

  assign tail_sum = SumW'(head_q) + SumW'(count_q);
  assign tail_idx = (tail_sum >= DepthSum) ? PtrW'(tail_sum - DepthSum) : PtrW'(tail_sum);

  assign back_sum = SumW'(head_q) + SumW'(count_q) - 1'b1;
  assign back_idx = (back_sum >= DepthSum) ? PtrW'(back_sum - DepthSum) : PtrW'(back_sum);

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = ST_DONE;
    wr_en    = 1'b0;
    wr_idx   = tail_idx;
    case (command_q)
      CMD_PUSH_FRONT: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          head_d  = head_prev;
          count_d = count_q + 1'b1;
          wr_en   = 1'b1;
          wr_idx  = head_prev;
        end
      end
      CMD_PUSH_BACK: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
          wr_en   = 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          head_d  = head_next;
          count_d = count_q - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end
      end
    endcase
    if (is_push && is_full) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      command_q <= command_i;
      word_q    <= WORD_BITS'($unsigned(value_i));
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
    end
  end

  // ring store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      ring_store_q[wr_idx] <= word_q;
    end
    if (cmd_i.read) begin
      front_rd_q <= ring_store_q[head_q];
      back_rd_q  <= ring_store_q[back_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      front_word_q    <= is_empty ? '0 : VALUE_BITS'(front_rd_q);
      back_word_q     <= is_empty ? '0 : VALUE_BITS'(back_rd_q);
      element_count_q <= COUNT_BITS'(count_q);
      is_empty_q      <= is_empty;
      rsp_status_q    <= status_q;
    end
  end

  assign front_word_o    = $signed(front_word_q);
  assign back_word_o     = $signed(back_word_q);
  assign element_count_o = element_count_q;
  assign is_empty_o      = is_empty_q;
  assign status_o        = rsp_status_q;

endmodule

`default_nettype wire

[rtl/core/double_ended_queue.sv]
// double_ended_queue: top level of the bounded double-ended queue
// joins deq_ctrl and deq_dp to the command and result interfaces; depends on deq_pkg
//
//   channel  | dir | payload                                            | handshake
//   cmd_i    | in  | command, value                                     | valid/ready
//   rsp_o    | out | front_word, back_word, element_count, is_empty,   | valid/ready
//            |     | status                                             |
//
// each command runs through accept, pointer update and store write, store read and
// result load, in that order; the store read follows the write
// a waiting result sits in the output register while the next command runs; that
// command holds in its last step until the result is taken
// reset clears head, count and handshake state; the store is not cleared
`default_nettype none

module double_ended_queue import deq_pkg::*; #(
  parameter int unsigned DEPTH     = DEQ_DEPTH,
  parameter int unsigned WORD_BITS = DEQ_WORD_BITS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  deq_cmd_if.sink    cmd_i,
  deq_rsp_if.source  rsp_o
);

  ctrl_cmd_t ctrl_cmd;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (ctrl_cmd)
  );

  deq_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .command_i       (cmd_i.command),
    .value_i         (cmd_i.value),
    .front_word_o    (rsp_o.front_word),
    .back_word_o     (rsp_o.back_word),
    .element_count_o (rsp_o.element_count),
    .is_empty_o      (rsp_o.is_empty),
    .status_o        (rsp_o.status)
  );

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// tb: self-checking bench for double_ended_queue, driven through deq_cmd_if and deq_rsp_if
// directed table then weighted random commands; each result is checked against its table
// row or a ring-buffer predictor; depends on deq_pkg, both interfaces, double_ended_queue
`default_nettype none

module tb;
  import deq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_BITS-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_BITS-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_BITS-1:0] CMD_RSVD7 = 3'd7;

  localparam logic [VALUE_BITS-1:0] W_MAX  = 32'h7FFF_FFFF;
  localparam logic [VALUE_BITS-1:0] W_MIN  = 32'h8000_0000;
  localparam logic [VALUE_BITS-1:0] W_ONES = 32'hFFFF_FFFF;
  localparam logic [VALUE_BITS-1:0] W_ZERO = 32'h0000_0000;

  localparam int HEAD_BITS     = $clog2(DEQ_DEPTH);
  localparam int MIXED_ITEMS   = 250;
  localparam int NEAR_FULL_ITEMS = 80;
  localparam int FILL_GUARD    = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = 20;
  localparam int STALL_LIMIT   = 5000;
  localparam int DIRECTED_ROWS = 23;

  typedef struct packed {
    logic [VALUE_BITS-1:0]  front_word;
    logic [VALUE_BITS-1:0]  back_word;
    logic [COUNT_BITS-1:0]  element_count;
    logic                   is_empty;
    logic [STATUS_BITS-1:0] status;
  } deq_snapshot_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]   command;
    logic [VALUE_BITS-1:0] value;
    logic                  typed;
    deq_snapshot_t         snapshot;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  deq_cmd_if cmd_bus ();
  deq_rsp_if rsp_bus ();

  double_ended_queue DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .rsp_o  (rsp_bus)
  );

  logic [VALUE_BITS-1:0] deq_ring [DEQ_DEPTH];
  logic [HEAD_BITS-1:0]  deq_head;
  logic [COUNT_BITS-1:0] deq_count;

  deq_snapshot_t awaited_snapshots [$];
  deq_snapshot_t oldest_snapshot;

  int fail_count    = 0;
  int sent_count    = 0;
  int checked_count = 0;
  int full_refusals = 0;
  int empty_misses  = 0;
  int peak_depth    = 0;
  int cmd_idle_pct  = 15;
  int rsp_idle_pct  = 58;
  int hold_requests = 0;
  int hold_granted  = 0;
  int hold_left     = 0;
  int fill_sent     = 0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CMD_PEEK,       W_ZERO, 1'b1, '{W_ZERO, W_ZERO, 11'd0, 1'b1, ST_EMPTY}},
    '{CMD_POP_FRONT,  W_ONES, 1'b1, '{W_ZERO, W_ZERO, 11'd0, 1'b1, ST_EMPTY}},
    '{CMD_POP_BACK,   W_MAX,  1'b1, '{W_ZERO, W_ZERO, 11'd0, 1'b1, ST_EMPTY}},
    '{CMD_RSVD5,      W_MIN,  1'b1, '{W_ZERO, W_ZERO, 11'd0, 1'b1, ST_EMPTY}},
    '{CMD_PUSH_BACK,  W_MAX,  1'b1, '{W_MAX,  W_MAX,  11'd1, 1'b0, ST_DONE}},
    '{CMD_PUSH_FRONT, W_MIN,  1'b1, '{W_MIN,  W_MAX,  11'd2, 1'b0, ST_DONE}},
    '{CMD_PUSH_BACK,  W_ZERO, 1'b1, '{W_MIN,  W_ZERO, 11'd3, 1'b0, ST_DONE}},
    '{CMD_PUSH_FRONT, W_ONES, 1'b1, '{W_ONES, W_ZERO, 11'd4, 1'b0, ST_DONE}},
    '{CMD_PEEK,       W_MAX,  1'b1, '{W_ONES, W_ZERO, 11'd4, 1'b0, ST_DONE}},
    '{CMD_RSVD6,      W_ZERO, 1'b1, '{W_ONES, W_ZERO, 11'd4, 1'b0, ST_DONE}},
    '{CMD_RSVD7,      W_ONES, 1'b1, '{W_ONES, W_ZERO, 11'd4, 1'b0, ST_DONE}},
    '{CMD_POP_FRONT,  W_ZERO, 1'b1, '{W_MIN,  W_ZERO, 11'd3, 1'b0, ST_DONE}},
    '{CMD_POP_BACK,   W_ZERO, 1'b1, '{W_MIN,  W_MAX,  11'd2, 1'b0, ST_DONE}},
    '{CMD_POP_BACK,   W_ONES, 1'b1, '{W_MIN,  W_MIN,  11'd1, 1'b0, ST_DONE}},
    '{CMD_POP_FRONT,  W_ZERO, 1'b1, '{W_ZERO, W_ZERO, 11'd0, 1'b1, ST_DONE}},
    '{CMD_POP_BACK,   W_ZERO, 1'b1, '{W_ZERO, W_ZERO, 11'd0, 1'b1, ST_EMPTY}},
    '{CMD_PUSH_FRONT, 32'h5555_5555, 1'b0, '0},
    '{CMD_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, '0},
    '{CMD_PUSH_BACK,  32'h0000_0001, 1'b0, '0},
    '{CMD_POP_BACK,   W_ZERO, 1'b0, '0},
    '{CMD_POP_FRONT,  W_ZERO, 1'b0, '0},
    '{CMD_POP_FRONT,  W_ZERO, 1'b0, '0},
    '{CMD_PEEK,       W_ZERO, 1'b0, '0}
  };

  function automatic int back_slot();
    return (int'(deq_head) + int'(deq_count) - 1) % DEQ_DEPTH;
  endfunction

  function automatic deq_snapshot_t next_snapshot(input logic [CMD_BITS-1:0] command,
                                                  input logic [VALUE_BITS-1:0] value);
    deq_snapshot_t snap;
    logic [STATUS_BITS-1:0] status;
    status = ST_DONE;
    if (command == CMD_PUSH_FRONT || command == CMD_PUSH_BACK) begin
      if (deq_count == DEQ_DEPTH) begin
        status = ST_FULL;
      end else if (command == CMD_PUSH_FRONT) begin
        deq_head = HEAD_BITS'((int'(deq_head) + DEQ_DEPTH - 1) % DEQ_DEPTH);
        deq_ring[deq_head] = value;
        deq_count = deq_count + 1'b1;
      end else begin
        deq_count = deq_count + 1'b1;
        deq_ring[back_slot()] = value;
      end
    end else if (deq_count == 0) begin
      status = ST_EMPTY;
    end else if (command == CMD_POP_FRONT) begin
      deq_head = HEAD_BITS'((int'(deq_head) + 1) % DEQ_DEPTH);
      deq_count = deq_count - 1'b1;
    end else if (command == CMD_POP_BACK) begin
      deq_count = deq_count - 1'b1;
    end
    if (deq_count == 0) begin
      snap.front_word = '0;
      snap.back_word  = '0;
      snap.is_empty   = 1'b1;
    end else begin
      snap.front_word = deq_ring[deq_head];
      snap.back_word  = deq_ring[back_slot()];
      snap.is_empty   = 1'b0;
    end
    snap.element_count = deq_count;
    snap.status        = status;
    return snap;
  endfunction

  function automatic logic [CMD_BITS-1:0] pick_command(input int push_pct, input int pop_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_pct) return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    if (roll < push_pct + pop_pct) return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    return CMD_BITS'($urandom_range(CMD_PEEK, CMD_RSVD7));
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(9))
      0: return W_MIN;
      1: return W_MAX;
      2: return W_ZERO;
      3: return W_ONES;
      default: return $urandom;
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [VALUE_BITS-1:0] expected,
                               input logic [VALUE_BITS-1:0] actual);
    if (actual !== expected) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
      fail_count++;
    end
  endtask

  task automatic send_command(input logic [CMD_BITS-1:0] command,
                              input logic [VALUE_BITS-1:0] value,
                              input logic typed, input deq_snapshot_t typed_snapshot);
    deq_snapshot_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < cmd_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_bus.valid   <= 1'b1;
    cmd_bus.command <= command;
    cmd_bus.value   <= value;
    do @(posedge clk_i); while (!cmd_bus.ready);
    predicted = next_snapshot(command, value);
    awaited_snapshots = {awaited_snapshots, (typed ? typed_snapshot : predicted)};
    sent_count++;
    if (predicted.status == ST_FULL) full_refusals++;
    if (predicted.status == ST_EMPTY) empty_misses++;
    if (int'(deq_count) > peak_depth) peak_depth = int'(deq_count);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    cmd_bus.valid <= 1'b0;
    while (awaited_snapshots.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result side: random ready, plus a long hold-off on request
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_granted != hold_requests) begin
        hold_left = HOLD_CYCLES;
        hold_granted++;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (awaited_snapshots.size() == 0) begin
        $display("%0t ns: result beat with nothing expected, expected none, actual %h %h",
                 $time, rsp_bus.front_word, rsp_bus.back_word);
        fail_count++;
      end else begin
        oldest_snapshot = awaited_snapshots[0];
        awaited_snapshots.delete(0);
        compare_field("front_word", oldest_snapshot.front_word, rsp_bus.front_word);
        compare_field("back_word", oldest_snapshot.back_word, rsp_bus.back_word);
        compare_field("element_count", VALUE_BITS'(oldest_snapshot.element_count),
                      VALUE_BITS'(rsp_bus.element_count));
        compare_field("is_empty", VALUE_BITS'(oldest_snapshot.is_empty),
                      VALUE_BITS'(rsp_bus.is_empty));
        compare_field("status", VALUE_BITS'(oldest_snapshot.status),
                      VALUE_BITS'(rsp_bus.status));
        checked_count++;
      end
    end
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, awaited_snapshots.size());
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cmd_bus.valid   = 1'b0;
    cmd_bus.command = CMD_PEEK;
    cmd_bus.value   = '0;
    deq_head        = '0;
    deq_count       = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_command(directed_rows[i].command, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].snapshot);

    // short mixed traffic around empty
    repeat (MIXED_ITEMS) send_command(pick_command(45, 45), pick_value(), 1'b0, '0);
    drain_results();

    // push-heavy traffic until the queue is full or FILL_GUARD commands are sent
    cmd_idle_pct = 58;
    rsp_idle_pct = 15;
    while (deq_count != DEQ_DEPTH && fill_sent < FILL_GUARD) begin
      send_command(pick_command(95, 3), pick_value(), 1'b0, '0);
      fill_sent++;
    end

    // churn at the full mark, with a long result hold-off
    cmd_idle_pct = 0;
    rsp_idle_pct = 0;
    hold_requests++;
    repeat (NEAR_FULL_ITEMS) send_command(pick_command(50, 40), pick_value(), 1'b0, '0);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("summary: %0d commands, %0d results checked, peak depth %0d of %0d",
             sent_count, checked_count, peak_depth, DEQ_DEPTH);
    $display("summary: %0d pushes refused when full, %0d pops or peeks on empty",
             full_refusals, empty_misses);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
